// ===== hw/rtl/asdc_pkg.sv =====
// ----------------------------------------------------------------------------
// asdc_pkg: shared definitions for the adaptive sleep duty controller
// Field widths, scaling constants, sleep limits and register indexes.
// ----------------------------------------------------------------------------
`default_nettype none

package asdc_pkg;

  // Payload and register widths
  localparam int unsigned CountW   = 16;
  localparam int unsigned ScanW    = 16;
  localparam int unsigned PeriodW  = 32;
  localparam int unsigned RateW    = 32;
  localparam int unsigned SleepW   = 14;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 32;

  // Divider datapath: count * scale over listen time, and period over scan sum
  localparam int unsigned DvdW     = 36;
  localparam int unsigned DvsW     = 48;
  localparam int unsigned StepCntW = 6;
  localparam int unsigned MulAW    = 32;
  localparam int unsigned MulBW    = 20;
  localparam int unsigned ProdW    = MulAW + MulBW;

  localparam logic [MulBW-1:0]  RateScale = MulBW'(1000000);
  localparam logic [RateW-1:0]  RateMax   = '1;
  localparam logic [SleepW-1:0] SleepMax  = SleepW'(12000);
  localparam logic [SleepW-1:0] SleepMin  = SleepW'(200);
  localparam logic [SleepW-1:0] StepSmall = SleepW'(100);
  localparam logic [SleepW-1:0] StepIdle  = SleepW'(200);
  localparam logic [SleepW-1:0] SleepRst  = SleepW'(1000);

  localparam logic [ScanW-1:0]   IntervalRst = ScanW'(960);
  localparam logic [ScanW-1:0]   WindowRst   = ScanW'(80);
  localparam logic [PeriodW-1:0] PeriodRst   = PeriodW'(2000000);

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] CfgScanInterval = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgScanWindow   = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgPeriodUs     = 2'd2;

endpackage

`default_nettype wire

// ===== hw/rtl/adaptive_sleep_duty_controller.sv =====
// ----------------------------------------------------------------------------
// adaptive_sleep_duty_controller
// Turns a per-period packet count into a normalized rate and steps a sleep
// duration up or down from the change in rate, using one shared divider.
// ----------------------------------------------------------------------------
//
//  Channel | Ports                                   | Handshake
//  --------+-----------------------------------------+-------------------
//  input   | in_packet_count                         | in_valid/in_ready
//  result  | out_norm_rate, out_sleep_ms,            | out_valid/out_ready
//          | out_enter_sleep, out_resume_advertising |
//  config  | cfg_index, cfg_wdata                    | cfg_we, no wait
//
//  An item runs from accept to result: a multiply, the divider steps for
//  period / (interval + window), a multiply, a check, the divider steps for
//  the rate, an update. Both divisions use the shared restoring divider.
//  A zero scan sum or zero listen time skips to the update with RateMax.
//  Reset is synchronous, active low; control and config registers return to defaults.
//  A pending result stalls only the final update, not the next input beat.
//
`default_nettype none

module adaptive_sleep_duty_controller (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               cfg_we,
  input  wire logic [asdc_pkg::CfgIdxW-1:0]       cfg_index,
  input  wire logic [asdc_pkg::CfgDataW-1:0]      cfg_wdata,
  input  wire logic                               in_valid,
  output logic                                    in_ready,
  input  wire logic [asdc_pkg::CountW-1:0]        in_packet_count,
  output logic                                    out_valid,
  input  wire logic                               out_ready,
  output logic [asdc_pkg::RateW-1:0]              out_norm_rate,
  output logic [asdc_pkg::SleepW-1:0]             out_sleep_ms,
  output logic                                    out_enter_sleep,
  output logic                                    out_resume_advertising
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_NUM  = 3'd1;
  localparam logic [2:0] S_DIV1 = 3'd2;
  localparam logic [2:0] S_MUL  = 3'd3;
  localparam logic [2:0] S_CHK  = 3'd4;
  localparam logic [2:0] S_DIV2 = 3'd5;
  localparam logic [2:0] S_UPD  = 3'd6;

  localparam logic [asdc_pkg::StepCntW-1:0] LastStep =
    asdc_pkg::StepCntW'(asdc_pkg::DvdW - 1);

  logic [2:0] state_r, state_nxt;

  logic [asdc_pkg::ScanW-1:0]   interval_r;
  logic [asdc_pkg::ScanW-1:0]   window_r;
  logic [asdc_pkg::PeriodW-1:0] period_r;

  logic [asdc_pkg::CountW-1:0]   count_r,  count_nxt;
  logic [asdc_pkg::DvdW-1:0]     num_r,    num_nxt;
  logic [asdc_pkg::DvsW-1:0]     listen_r, listen_nxt;
  logic [asdc_pkg::DvdW-1:0]     dvd_r,    dvd_nxt;
  logic [asdc_pkg::DvsW-1:0]     dvs_r,    dvs_nxt;
  logic [asdc_pkg::DvsW-1:0]     rem_r,    rem_nxt;
  logic [asdc_pkg::StepCntW-1:0] step_r,   step_nxt;
  logic [asdc_pkg::RateW-1:0]    rate_r,   rate_nxt;

  logic [asdc_pkg::SleepW-1:0] sleep_r, sleep_nxt;
  logic [asdc_pkg::RateW-1:0]  prev_r,  prev_nxt;
  logic                        have_prev_r, have_prev_nxt;

  logic                         out_valid_r, out_valid_nxt;
  logic [asdc_pkg::RateW-1:0]   out_rate_r,  out_rate_nxt;
  logic [asdc_pkg::SleepW-1:0]  out_sleep_r, out_sleep_nxt;
  logic                         out_enter_r, out_enter_nxt;
  logic                         out_resume_r, out_resume_nxt;

  // Shared multiplier and one divider step
  logic [asdc_pkg::MulAW-1:0] mul_a;
  logic [asdc_pkg::MulBW-1:0] mul_b;
  logic [asdc_pkg::ProdW-1:0] prod;
  logic [asdc_pkg::ScanW:0]   scan_sum;
  logic [asdc_pkg::DvsW:0]    trial;
  logic [asdc_pkg::DvsW:0]    diff;
  logic                       fits;

  logic [asdc_pkg::RateW-1:0]  prev_eff;
  logic [asdc_pkg::SleepW-1:0] sleep_upd;
  logic                        enter_upd, resume_upd;
  logic                        out_free;

  assign scan_sum = {1'b0, interval_r} + {1'b0, window_r};
  assign prod     = asdc_pkg::ProdW'(mul_a) * asdc_pkg::ProdW'(mul_b);
  assign trial    = {rem_r, dvd_r[asdc_pkg::DvdW-1]};
  assign diff     = trial - {1'b0, dvs_r};
  assign fits     = trial >= {1'b0, dvs_r};
  assign out_free = !out_valid_r || out_ready;

  always_comb begin
    if (state_r == S_MUL) begin
      mul_a = dvd_r[asdc_pkg::MulAW-1:0];
      mul_b = asdc_pkg::MulBW'(window_r);
    end else begin
      mul_a = asdc_pkg::MulAW'(count_r);
      mul_b = asdc_pkg::RateScale;
    end
  end

  // Sleep duration update from the new rate against the previous one.
  always_comb begin
    prev_eff   = have_prev_r ? prev_r : rate_r;
    sleep_upd  = sleep_r;
    enter_upd  = 1'b0;
    resume_upd = 1'b0;
    if (rate_r == '0) begin
      enter_upd = 1'b1;
      if (prev_eff == '0) begin
        sleep_upd = (sleep_r + asdc_pkg::StepIdle > asdc_pkg::SleepMax) ?
                    asdc_pkg::SleepMax : sleep_r + asdc_pkg::StepIdle;
      end
    end else if (rate_r > prev_eff) begin
      sleep_upd  = (sleep_r < asdc_pkg::SleepMin + asdc_pkg::StepSmall) ?
                   asdc_pkg::SleepMin : sleep_r - asdc_pkg::StepSmall;
      resume_upd = (prev_eff == '0);
    end else if (rate_r < prev_eff) begin
      sleep_upd = (sleep_r + asdc_pkg::StepSmall > asdc_pkg::SleepMax) ?
                  asdc_pkg::SleepMax : sleep_r + asdc_pkg::StepSmall;
    end
  end

  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    num_nxt        = num_r;
    listen_nxt     = listen_r;
    dvd_nxt        = dvd_r;
    dvs_nxt        = dvs_r;
    rem_nxt        = rem_r;
    step_nxt       = step_r;
    rate_nxt       = rate_r;
    sleep_nxt      = sleep_r;
    prev_nxt       = prev_r;
    have_prev_nxt  = have_prev_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_rate_nxt   = out_rate_r;
    out_sleep_nxt  = out_sleep_r;
    out_enter_nxt  = out_enter_r;
    out_resume_nxt = out_resume_r;

    unique case (state_r) inside
      S_IDLE: begin
        if (in_valid) begin
          count_nxt = in_packet_count;
          state_nxt = S_NUM;
        end
      end
      S_NUM: begin
        num_nxt  = prod[asdc_pkg::DvdW-1:0];
        dvd_nxt  = asdc_pkg::DvdW'(period_r);
        dvs_nxt  = asdc_pkg::DvsW'(scan_sum);
        rem_nxt  = '0;
        step_nxt = '0;
        if (scan_sum == '0) begin
          rate_nxt  = asdc_pkg::RateMax;
          state_nxt = S_UPD;
        end else begin
          state_nxt = S_DIV1;
        end
      end
      S_DIV1, S_DIV2: begin
        // One restoring step: quotient bits shift in at the bottom of dvd_r.
        rem_nxt  = fits ? diff[asdc_pkg::DvsW-1:0] : trial[asdc_pkg::DvsW-1:0];
        dvd_nxt  = {dvd_r[asdc_pkg::DvdW-2:0], fits};
        step_nxt = step_r + asdc_pkg::StepCntW'(1);
        if (step_r == LastStep) begin
          state_nxt = (state_r == S_DIV1) ? S_MUL : S_UPD;
          if (state_r == S_DIV2) begin
            rate_nxt = (dvd_nxt[asdc_pkg::DvdW-1:asdc_pkg::RateW] != '0) ?
                       asdc_pkg::RateMax : dvd_nxt[asdc_pkg::RateW-1:0];
          end
        end
      end
      S_MUL: begin
        listen_nxt = prod[asdc_pkg::DvsW-1:0];
        state_nxt  = S_CHK;
      end
      S_CHK: begin
        dvd_nxt  = num_r;
        dvs_nxt  = listen_r;
        rem_nxt  = '0;
        step_nxt = '0;
        if (listen_r == '0) begin
          rate_nxt  = asdc_pkg::RateMax;
          state_nxt = S_UPD;
        end else begin
          state_nxt = S_DIV2;
        end
      end
      S_UPD: begin
        if (out_free) begin
          sleep_nxt      = sleep_upd;
          prev_nxt       = rate_r;
          have_prev_nxt  = 1'b1;
          out_valid_nxt  = 1'b1;
          out_rate_nxt   = rate_r;
          out_sleep_nxt  = sleep_upd;
          out_enter_nxt  = enter_upd;
          out_resume_nxt = resume_upd;
          state_nxt      = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      interval_r  <= asdc_pkg::IntervalRst;
      window_r    <= asdc_pkg::WindowRst;
      period_r    <= asdc_pkg::PeriodRst;
      sleep_r     <= asdc_pkg::SleepRst;
      prev_r      <= '0;
      have_prev_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      sleep_r     <= sleep_nxt;
      prev_r      <= prev_nxt;
      have_prev_r <= have_prev_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          asdc_pkg::CfgScanInterval: interval_r <= cfg_wdata[asdc_pkg::ScanW-1:0];
          asdc_pkg::CfgScanWindow:   window_r   <= cfg_wdata[asdc_pkg::ScanW-1:0];
          asdc_pkg::CfgPeriodUs:     period_r   <= cfg_wdata[asdc_pkg::PeriodW-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    count_r      <= count_nxt;
    num_r        <= num_nxt;
    listen_r     <= listen_nxt;
    dvd_r        <= dvd_nxt;
    dvs_r        <= dvs_nxt;
    rem_r        <= rem_nxt;
    step_r       <= step_nxt;
    rate_r       <= rate_nxt;
    out_rate_r   <= out_rate_nxt;
    out_sleep_r  <= out_sleep_nxt;
    out_enter_r  <= out_enter_nxt;
    out_resume_r <= out_resume_nxt;
  end

  assign in_ready               = (state_r == S_IDLE);
  assign out_valid              = out_valid_r;
  assign out_norm_rate          = out_rate_r;
  assign out_sleep_ms           = out_sleep_r;
  assign out_enter_sleep        = out_enter_r;
  assign out_resume_advertising = out_resume_r;

  // The sleep duration always stays inside its clamp.
  a_sleep_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_sleep_ms >= asdc_pkg::SleepMin &&
                   out_sleep_ms <= asdc_pkg::SleepMax))
    else $error("sleep duration outside its limits");

  // Sleep is flagged exactly for a zero rate, and never with a resume.
  a_flags: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_enter_sleep == (out_norm_rate == '0)) &&
                   !(out_enter_sleep && out_resume_advertising)))
    else $error("result flags disagree with the rate");

  // An accepted beat always starts the rate computation.
  a_start: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (state_r == S_NUM))
    else $error("accepted beat did not start the computation");

  // The divider never runs past its last step.
  a_step: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV1 || state_r == S_DIV2) |-> (step_r <= LastStep))
    else $error("divider step counter overran");

  // A waiting result is never overwritten by the next update.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> $stable(out_norm_rate) && $stable(out_sleep_ms))
    else $error("pending result changed");

endmodule

`default_nettype wire
